>>> src/assert_macros.svh
// assertion macros for the rtl of the congestion window block
// no dependencies; include by bare file name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a given clock and active-low reset
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check on the block clock clk_i and reset rst_ni
`define ASSERT_CHK_DEF(lbl, prop, msg) `ASSERT_CHK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> src/scw_pkg.sv
// package for the search congestion window block: defaults, codes, types
// no dependencies
`default_nettype none

package scw_pkg;

  // default parameter values
  localparam int unsigned MaxFramesDefault = 64;
  localparam int unsigned FracBitsDefault  = 16;
  // integer bits of the window format
  localparam int unsigned IntBits = 7;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_RESPONSE = 2'd0,
    FUNC_EXPIRE   = 2'd1,
    FUNC_STOP     = 2'd2
  } func_e;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // per-item result flags
  typedef struct packed {
    logic accepted;
    logic restart;
    logic boost;
    logic congest;
  } flags_t;

endpackage

`default_nettype wire

>>> src/search_congestion_window_top.sv
// search congestion window: window/threshold state, response counting and
// an iterative restoring divider for the additive-increase reciprocal
// depends on scw_pkg and assert_macros.svh
//
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    func_i .. searches_sent_i
//   result    out_valid_o / out_ready_i  frames_per_try_o .. congestion_seen_o
//   config    cfg_we_i                   cfg_wdata_i (boost_possible)
//
// a response, stop or expire without additive increase goes from the idle state
// through the done state into the output register; an expire with additive
// increase first passes through the divider state, which forms the FRAC_BITS + 1
// quotient bits one bit per cycle, before it reaches the done state.
// the input is taken again once the previous item has moved into the output
// register, so a new item is transferred while a result still waits; a stalled
// result holds the sequencer until the output register frees up.
// reset is asynchronous and returns the window to one frame, threshold to
// all ones, counters and sequence window to zero.
`default_nettype none
`include "assert_macros.svh"

module search_congestion_window_top #(
  parameter int unsigned MAX_FRAMES = scw_pkg::MaxFramesDefault,
  parameter int unsigned FRAC_BITS  = scw_pkg::FracBitsDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_wdata_i,
  // input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [1:0]                           func_i,
  input  wire logic [31:0]                          resp_seq_no_i,
  input  wire logic                                 resp_seq_valid_i,
  input  wire logic                                 requests_waiting_i,
  input  wire logic [31:0]                          round_seq_begin_i,
  input  wire logic [31:0]                          round_seq_next_i,
  input  wire logic [31:0]                          searches_sent_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [scw_pkg::IntBits+FRAC_BITS-1:0]     frames_per_try_o,
  output logic [scw_pkg::IntBits+FRAC_BITS-1:0]     threshold_now_o,
  output logic                                      response_accepted_o,
  output logic                                      restart_now_o,
  output logic                                      boost_now_o,
  output logic                                      congestion_seen_o
);
  import scw_pkg::*;

  localparam int unsigned WinW  = IntBits + FRAC_BITS;
  localparam int unsigned QuotW = FRAC_BITS + 1;
  localparam int unsigned CntW  = $clog2(FRAC_BITS + 1);

  localparam logic [WinW-1:0] OneFrame = WinW'(1) << FRAC_BITS;
  localparam logic [WinW-1:0] HalfOne  = WinW'(1) << (FRAC_BITS - 1);
  localparam logic [WinW-1:0] Limit    = WinW'(MAX_FRAMES) << FRAC_BITS;
  localparam logic [WinW-1:0] WinMax   = '1;
  localparam logic [31:0]     CountMax = '1;

  state_e            state_q, state_d;
  logic [WinW-1:0]   window_q, window_d;
  logic [WinW-1:0]   thresh_q, thresh_d;
  logic [31:0]       attempt_q, attempt_d;
  logic [31:0]       resp_cnt_q, resp_cnt_d;
  logic [31:0]       seq_low_q, seq_low_d;
  logic [31:0]       seq_high_q, seq_high_d;
  logic              halted_q, halted_d;
  logic              boost_en_q;
  flags_t            flags_q, flags_d;
  // divider registers
  logic [WinW-1:0]   rem_q, rem_d;
  logic [QuotW-1:0]  quot_q, quot_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  // output register
  logic              out_valid_q;
  logic [WinW-1:0]   out_win_q;
  logic [WinW-1:0]   out_thr_q;
  flags_t            out_flags_q;

  // divider step and increase datapath
  logic [WinW:0]     rem_shift;
  logic              rem_ge;
  logic [QuotW-1:0]  quot_next;
  logic [WinW:0]     win_sum;
  logic [WinW:0]     win_double;
  logic              seq_hit;
  logic [31:0]       resp_inc;
  logic              out_free;

  assign rem_shift  = {rem_q, 1'b0};
  assign rem_ge     = rem_shift >= {1'b0, window_q};
  assign quot_next  = {quot_q[QuotW-2:0], rem_ge};
  assign win_sum    = {1'b0, window_q} + (WinW + 1)'(quot_next);
  assign win_double = {window_q, 1'b0};
  assign seq_hit    = !resp_seq_valid_i ||
                      (seq_low_q <= resp_seq_no_i && seq_high_q >= resp_seq_no_i);
  assign resp_inc   = resp_cnt_q + 32'd1;
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer and state update
  always_comb begin
    state_d    = state_q;
    window_d   = window_q;
    thresh_d   = thresh_q;
    attempt_d  = attempt_q;
    resp_cnt_d = resp_cnt_q;
    seq_low_d  = seq_low_q;
    seq_high_d = seq_high_q;
    halted_d   = halted_q;
    flags_d    = flags_q;
    rem_d      = rem_q;
    quot_d     = quot_q;
    cnt_d      = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          flags_d = '0;
          state_d = S_DONE;
          case (func_e'(func_i))
            FUNC_RESPONSE: begin
              if (!halted_q && seq_hit && resp_cnt_q != CountMax) begin
                resp_cnt_d       = resp_inc;
                flags_d.accepted = 1'b1;
                flags_d.restart  = (resp_inc == attempt_q) && requests_waiting_i;
              end
            end
            FUNC_EXPIRE: begin
              flags_d.boost = (resp_cnt_q != 32'd0) && boost_en_q;
              if (attempt_q != 32'd0) begin
                if (resp_cnt_q == attempt_q) begin
                  if (window_q < Limit) begin
                    if (window_q < thresh_q) begin
                      // slow start: double, capped at the threshold
                      window_d = (win_double > {1'b0, thresh_q}) ? thresh_q :
                                 win_double[WinW-1:0];
                    end else begin
                      // additive increase: start the reciprocal division
                      rem_d   = HalfOne;
                      quot_d  = '0;
                      cnt_d   = CntW'(FRAC_BITS);
                      state_d = S_DIV;
                    end
                  end
                end else begin
                  thresh_d        = {1'b0, window_q[WinW-1:1]};
                  window_d        = OneFrame;
                  flags_d.congest = 1'b1;
                end
              end
              // open the next round
              seq_low_d  = round_seq_begin_i;
              seq_high_d = round_seq_next_i - 32'd1;
              attempt_d  = searches_sent_i;
              resp_cnt_d = '0;
            end
            FUNC_STOP: begin
              halted_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        rem_d  = rem_ge ? WinW'(rem_shift - {1'b0, window_q}) : rem_shift[WinW-1:0];
        quot_d = quot_next;
        if (cnt_q == '0) begin
          window_d = win_sum[WinW] ? WinMax : win_sum[WinW-1:0];
          state_d  = S_DONE;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= OneFrame;
      thresh_q    <= WinMax;
      attempt_q   <= '0;
      resp_cnt_q  <= '0;
      seq_low_q   <= '0;
      seq_high_q  <= '0;
      halted_q    <= 1'b0;
      boost_en_q  <= 1'b0;
      flags_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      window_q   <= window_d;
      thresh_q   <= thresh_d;
      attempt_q  <= attempt_d;
      resp_cnt_q <= resp_cnt_d;
      seq_low_q  <= seq_low_d;
      seq_high_q <= seq_high_d;
      halted_q   <= halted_d;
      flags_q    <= flags_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        boost_en_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath and output payload
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (state_q == S_DONE && out_free) begin
      out_win_q   <= window_q;
      out_thr_q   <= thresh_q;
      out_flags_q <= flags_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frames_per_try_o    = out_win_q;
  assign threshold_now_o     = out_thr_q;
  assign response_accepted_o = out_flags_q.accepted;
  assign restart_now_o       = out_flags_q.restart;
  assign boost_now_o         = out_flags_q.boost;
  assign congestion_seen_o   = out_flags_q.congest;

  // checks
  `ASSERT_CHK_DEF(a_win_min, window_q >= OneFrame, "window below one frame")
  `ASSERT_CHK_DEF(a_div_end, (state_q == S_DIV && cnt_q == '0) |=> (state_q == S_DONE),
                  "divider did not finish")
  `ASSERT_CHK_DEF(a_congest_win, (out_valid_o && congestion_seen_o) |->
                  (frames_per_try_o == OneFrame), "congestion without window reset")
  `ASSERT_CHK_DEF(a_flag_mix, out_valid_o |-> !(response_accepted_o && congestion_seen_o),
                  "response and expire flags together")

endmodule

`default_nettype wire
